FILE: rtl/core/bfca_pkg.sv
// Shared constants and types for the best-fit chunk allocator.
package bfca_pkg;

  localparam int unsigned POOL_UNITS_DEF = 1024;

  localparam logic [14:0] MAX_REPORT = 15'd32736;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOFIT   = 2'd1;
  localparam logic [1:0] ST_BADFREE = 2'd2;

  typedef struct packed {
    logic en;
    logic head;
    logic free;
  } wr_ctl_t;

endpackage

FILE: rtl/core/best_fit_chunk_allocator.sv
// Best-fit chunk allocator: sequencer over a chunk table with one read and one write port.
//
// Input channel: in_valid_i / in_stall_o with operation_i, request_bytes_i,
// release_offset_i. Output channel: out_valid_o / out_stall_i with status_o,
// data_offset_o, max_free_bytes_o. Each request gives exactly one result.
// One request is worked on at a time; in_stall_o is high while busy.
// Allocate scans every table entry once, one per cycle. Free reads the chunk
// and its right neighbour, then walks down one unit per cycle to the left
// neighbour header. Query scans the table and then rewrites every entry,
// one per cycle, to the reset pool. After reset the same clearing pass runs
// before the first request is accepted. The table read port is the limit:
// one entry a cycle.
// A result waits in the output register while out_stall_i is high; the next
// request can still be accepted, and its result is held back until the
// output register has been taken.
module best_fit_chunk_allocator #(
  parameter int unsigned POOL_UNITS = bfca_pkg::POOL_UNITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [14:0] request_bytes_i,
  input  logic [14:0] release_offset_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [14:0] data_offset_o,
  output logic [14:0] max_free_bytes_o
);
  import bfca_pkg::*;

  localparam int unsigned AW = $clog2(POOL_UNITS);
  localparam int unsigned CW = AW + 12;

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_ASCAN = 4'd2;
  localparam logic [3:0] S_AWR0  = 4'd3;
  localparam logic [3:0] S_AWR1  = 4'd4;
  localparam logic [3:0] S_FRD   = 4'd5;
  localparam logic [3:0] S_FCHK  = 4'd6;
  localparam logic [3:0] S_FNCHK = 4'd7;
  localparam logic [3:0] S_PSCAN = 4'd8;
  localparam logic [3:0] S_FEND  = 4'd9;
  localparam logic [3:0] S_FEND2 = 4'd10;
  localparam logic [3:0] S_QSCAN = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;

  logic [3:0]    st_q, st_d;
  logic [AW:0]   cnt_q, cnt_d;
  logic          pend_q, pend_d;
  logic [AW-1:0] pidx_q, pidx_d;
  logic [31:0]   ctr_q, ctr_d;
  logic          clr_after_q, clr_after_d;
  logic [10:0]   need_q, need_d;
  logic          bfound_q, bfound_d;
  logic [AW-1:0] bidx_q, bidx_d;
  logic [AW-1:0] bun_q, bun_d;
  logic [31:0]   bsp_q, bsp_d;
  logic          split_q, split_d;
  logic [AW-1:0] sidx_q, sidx_d;
  logic [AW-1:0] rest_q, rest_d;
  logic [AW-1:0] u_q, u_d;
  logic [AW-1:0] uun_q, uun_d;
  logic [AW-1:0] nidx_q, nidx_d;
  logic          nval_q, nval_d;
  logic          pfound_q, pfound_d;
  logic          pfr_q, pfr_d;
  logic [AW-1:0] pun_q, pun_d;
  logic [AW-1:0] qbest_q, qbest_d;
  logic [1:0]    rs_q, rs_d;
  logic [14:0]   roff_q, roff_d;
  logic [14:0]   rmax_q, rmax_d;

  logic          ov_q;
  logic [1:0]    ost_q;
  logic [14:0]   ooff_q, omax_q;

  wr_ctl_t       wr_ctl;
  logic [AW-1:0] wr_addr, wr_units, rd_addr;
  logic [31:0]   wr_stamp;
  logic          rd_head, rd_free;
  logic [AW-1:0] rd_units;
  logic [31:0]   rd_stamp;

  logic          accept, out_load;
  logic [15:0]   req_sum;
  logic [31:0]   urel;
  logic          fbad;
  logic [AW:0]   cnt_m1;
  logic [CW-1:0] n_ext, s_ext;
  logic [31:0]   age_i, age_b, bytes, offw;
  logic          cand, better;
  logic [AW:0]   b1;

  bfca_store #(.POOL_UNITS(POOL_UNITS), .AW(AW)) u_store (
    .clk_i      (clk_i),
    .wr_ctl_i   (wr_ctl),
    .wr_addr_i  (wr_addr),
    .wr_units_i (wr_units),
    .wr_stamp_i (wr_stamp),
    .rd_addr_i  (rd_addr),
    .rd_head_o  (rd_head),
    .rd_free_o  (rd_free),
    .rd_units_o (rd_units),
    .rd_stamp_o (rd_stamp)
  );

  assign in_stall_o       = (st_q != S_IDLE);
  assign accept           = in_valid_i && !in_stall_o;
  assign out_valid_o      = ov_q;
  assign status_o         = ost_q;
  assign data_offset_o    = ooff_q;
  assign max_free_bytes_o = omax_q;
  assign out_load         = (st_q == S_OUT) && (!ov_q || !out_stall_i);

  assign req_sum = {1'b0, request_bytes_i} + 16'd31;
  assign urel    = 32'(release_offset_i[14:5]) - 32'd1;
  assign fbad    = (release_offset_i[4:0] != 5'd0) || (release_offset_i[14:5] == 10'd0) ||
                   (urel >= 32'(POOL_UNITS));
  assign cnt_m1  = cnt_q - 1'b1;
  assign n_ext   = CW'(u_q) + CW'(1) + CW'(rd_units);
  assign s_ext   = CW'(bidx_q) + CW'(1) + CW'(need_q);
  assign age_i   = ctr_q - rd_stamp;
  assign age_b   = ctr_q - bsp_q;
  assign cand    = rd_head && rd_free && (CW'(rd_units) >= CW'(need_q));
  assign better  = !bfound_q || (rd_units < bun_q) || ((rd_units == bun_q) && (age_i > age_b));
  assign bytes   = 32'(qbest_q) << 5;
  assign b1      = {1'b0, bidx_q} + 1'b1;
  assign offw    = 32'(b1) << 5;

  always_comb begin
    case (st_q)
      S_FRD:   rd_addr = u_q;
      S_FCHK:  rd_addr = n_ext[AW-1:0];
      S_PSCAN: rd_addr = cnt_m1[AW-1:0];
      default: rd_addr = cnt_q[AW-1:0];
    endcase
  end

  always_comb begin
    st_d = st_q; cnt_d = cnt_q; pend_d = pend_q; pidx_d = pidx_q; ctr_d = ctr_q;
    clr_after_d = clr_after_q; need_d = need_q; bfound_d = bfound_q; bidx_d = bidx_q;
    bun_d = bun_q; bsp_d = bsp_q; split_d = split_q; sidx_d = sidx_q; rest_d = rest_q;
    u_d = u_q; uun_d = uun_q; nidx_d = nidx_q; nval_d = nval_q; pfound_d = pfound_q;
    pfr_d = pfr_q; pun_d = pun_q; qbest_d = qbest_q; rs_d = rs_q; roff_d = roff_q;
    rmax_d = rmax_q;
    wr_ctl = '0; wr_addr = cnt_q[AW-1:0]; wr_units = '0; wr_stamp = '0;
    case (st_q)
      S_CLR: begin
        wr_ctl.en = 1'b1;
        if (cnt_q == '0) begin
          wr_ctl.head = 1'b1;
          wr_ctl.free = 1'b1;
          wr_units    = AW'(POOL_UNITS - 1);
        end
        if (cnt_q == (AW+1)'(POOL_UNITS - 1)) begin
          st_d = S_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (accept) begin
          rs_d = ST_OK; roff_d = '0; rmax_d = '0;
          cnt_d = '0; pend_d = 1'b0; bfound_d = 1'b0; qbest_d = '0;
          clr_after_d = 1'b0;
          need_d = (request_bytes_i == 15'd0) ? 11'd1 : req_sum[15:5];
          u_d = AW'(urel);
          case (operation_i)
            OP_ALLOC: st_d = S_ASCAN;
            OP_FREE: begin
              if (fbad) begin
                rs_d = ST_BADFREE;
                st_d = S_OUT;
              end else begin
                st_d = S_FRD;
              end
            end
            OP_QUERY: st_d = S_QSCAN;
            default:  st_d = S_OUT;
          endcase
        end
      end
      S_ASCAN: begin
        if (pend_q && cand && better) begin
          bfound_d = 1'b1; bidx_d = pidx_q; bun_d = rd_units; bsp_d = rd_stamp;
        end
        pend_d = (cnt_q < (AW+1)'(POOL_UNITS));
        pidx_d = cnt_q[AW-1:0];
        if (pend_d) cnt_d = cnt_q + 1'b1;
        if (!pend_q && cnt_q == (AW+1)'(POOL_UNITS)) begin
          if (!bfound_q) begin
            rs_d = ST_NOFIT;
            st_d = S_OUT;
          end else begin
            rest_d  = bun_q - AW'(need_q);
            split_d = (rest_d >= AW'(2)) && (s_ext < CW'(POOL_UNITS));
            sidx_d  = s_ext[AW-1:0];
            roff_d  = offw[14:0];
            st_d    = S_AWR0;
          end
        end
      end
      S_AWR0: begin
        wr_ctl.en = 1'b1; wr_ctl.head = 1'b1;
        wr_addr = bidx_q; wr_units = split_q ? AW'(need_q) : bun_q; wr_stamp = bsp_q;
        st_d = split_q ? S_AWR1 : S_OUT;
      end
      S_AWR1: begin
        wr_ctl.en = 1'b1; wr_ctl.head = 1'b1; wr_ctl.free = 1'b1;
        wr_addr = sidx_q; wr_units = rest_q - AW'(1); wr_stamp = ctr_q;
        ctr_d = ctr_q + 32'd1;
        st_d = S_OUT;
      end
      S_FRD: st_d = S_FCHK;
      S_FCHK: begin
        if (!rd_head || rd_free) begin
          rs_d = ST_BADFREE;
          st_d = S_OUT;
        end else begin
          uun_d  = rd_units;
          nidx_d = n_ext[AW-1:0];
          nval_d = (n_ext < CW'(POOL_UNITS));
          st_d   = S_FNCHK;
        end
      end
      S_FNCHK: begin
        if (nval_q && rd_head && rd_free) begin
          uun_d = uun_q + AW'(1) + rd_units;
          wr_ctl.en = 1'b1; wr_addr = nidx_q;
        end
        cnt_d = {1'b0, u_q}; pend_d = 1'b0; pfound_d = 1'b0;
        st_d = S_PSCAN;
      end
      S_PSCAN: begin
        if (pend_q && rd_head) begin
          pfound_d = 1'b1; pidx_d = pidx_q; pfr_d = rd_free; pun_d = rd_units;
          st_d = S_FEND;
        end else if (cnt_q == '0 && !pend_q) begin
          st_d = S_FEND;
        end else begin
          pend_d = (cnt_q != '0);
          if (cnt_q != '0) begin
            pidx_d = cnt_m1[AW-1:0];
            cnt_d  = cnt_m1;
          end
        end
      end
      S_FEND: begin
        wr_ctl.en = 1'b1; wr_addr = u_q;
        if (pfound_q && pfr_q) begin
          st_d = S_FEND2;
        end else begin
          wr_ctl.head = 1'b1; wr_ctl.free = 1'b1;
          wr_units = uun_q; wr_stamp = ctr_q;
          ctr_d = ctr_q + 32'd1;
          st_d = S_OUT;
        end
      end
      S_FEND2: begin
        wr_ctl.en = 1'b1; wr_ctl.head = 1'b1; wr_ctl.free = 1'b1;
        wr_addr = pidx_q; wr_units = pun_q + AW'(1) + uun_q; wr_stamp = ctr_q;
        ctr_d = ctr_q + 32'd1;
        st_d = S_OUT;
      end
      S_QSCAN: begin
        if (pend_q && rd_head && rd_free && rd_units > qbest_q) qbest_d = rd_units;
        pend_d = (cnt_q < (AW+1)'(POOL_UNITS));
        if (pend_d) cnt_d = cnt_q + 1'b1;
        if (!pend_q && cnt_q == (AW+1)'(POOL_UNITS)) begin
          rmax_d = (bytes > 32'(MAX_REPORT)) ? MAX_REPORT : bytes[14:0];
          clr_after_d = 1'b1;
          st_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          if (clr_after_q) begin
            cnt_d = '0;
            ctr_d = 32'd1;
            st_d  = S_CLR;
          end else begin
            st_d = S_IDLE;
          end
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_CLR;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      ctr_q       <= 32'd1;
      clr_after_q <= 1'b0;
      bfound_q    <= 1'b0;
      pfound_q    <= 1'b0;
      ov_q        <= 1'b0;
    end else begin
      st_q        <= st_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      ctr_q       <= ctr_d;
      clr_after_q <= clr_after_d;
      bfound_q    <= bfound_d;
      pfound_q    <= pfound_d;
      if (out_load) begin
        ov_q <= 1'b1;
      end else if (!out_stall_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q  <= pidx_d;
    need_q  <= need_d;
    bidx_q  <= bidx_d;
    bun_q   <= bun_d;
    bsp_q   <= bsp_d;
    split_q <= split_d;
    sidx_q  <= sidx_d;
    rest_q  <= rest_d;
    u_q     <= u_d;
    uun_q   <= uun_d;
    nidx_q  <= nidx_d;
    nval_q  <= nval_d;
    pfr_q   <= pfr_d;
    pun_q   <= pun_d;
    qbest_q <= qbest_d;
    rs_q    <= rs_d;
    roff_q  <= roff_d;
    rmax_q  <= rmax_d;
    if (out_load) begin
      ost_q  <= rs_q;
      ooff_q <= roff_q;
      omax_q <= rmax_q;
    end
  end

endmodule

FILE: rtl/core/bfca_store.sv
// Per-unit chunk table: header, free flag, data units and free stamp.
module bfca_store #(
  parameter int unsigned POOL_UNITS = bfca_pkg::POOL_UNITS_DEF,
  parameter int unsigned AW = $clog2(POOL_UNITS)
) (
  input  logic             clk_i,
  input  bfca_pkg::wr_ctl_t wr_ctl_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [AW-1:0]    wr_units_i,
  input  logic [31:0]      wr_stamp_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic             rd_head_o,
  output logic             rd_free_o,
  output logic [AW-1:0]    rd_units_o,
  output logic [31:0]      rd_stamp_o
);
  import bfca_pkg::*;

  logic          head_mem  [POOL_UNITS];
  logic          free_mem  [POOL_UNITS];
  logic [AW-1:0] units_mem [POOL_UNITS];
  logic [31:0]   stamp_mem [POOL_UNITS];

  always_ff @(posedge clk_i) begin
    if (wr_ctl_i.en) begin
      head_mem[wr_addr_i]  <= wr_ctl_i.head;
      free_mem[wr_addr_i]  <= wr_ctl_i.free;
      units_mem[wr_addr_i] <= wr_units_i;
      stamp_mem[wr_addr_i] <= wr_stamp_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_head_o  <= head_mem[rd_addr_i];
    rd_free_o  <= free_mem[rd_addr_i];
    rd_units_o <= units_mem[rd_addr_i];
    rd_stamp_o <= stamp_mem[rd_addr_i];
  end

endmodule
